### design/mltc_pkg.sv
// Shared types, constants and elaboration-time tables of the mixing-length
// turbulence column. No dependencies; every other design file imports this.

package mltc_pkg;

  // Default width of the running length and of the internal results.
  localparam int VALUE_WIDTH_DEF = 32;

  // Configuration port.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 17;

  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_MAX = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT  = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KAPPA     = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CMU       = 8'd3;

  localparam logic [16:0] ALPHA_MAX_RST = 17'd36045;
  localparam logic [15:0] EXPONENT_RST  = 16'd4096;
  localparam logic [15:0] KAPPA_RST     = 16'd14746;
  localparam logic [15:0] CMU_RST       = 16'd10769;

  // 1.0 in Q1.16 and the lower bound of the length used as a divisor.
  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam int          LM_SMALL = 1678;

  // Datapath operations issued by the controller.
  typedef enum logic [5:0] {
    OP_NONE,
    OP_DIV_INIT_R,
    OP_DIV_STEP,
    OP_R_SET,
    OP_P_ONE,
    OP_P_ZERO,
    OP_PW_NORM,
    OP_SQ_MUL,
    OP_SQ_ACC,
    OP_LOG_MUL,
    OP_LOG_ACC,
    OP_EXP_MUL,
    OP_EXP_ACC,
    OP_P_SET,
    OP_LD_INC1,
    OP_LD_INC2,
    OP_LM_UPD,
    OP_LD_SQ,
    OP_LD_NUT,
    OP_NUT_SET,
    OP_DIV_INIT_Q,
    OP_LD_K,
    OP_K_SET,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_LD_SC,
    OP_LD_EN,
    OP_DIV_INIT_E,
    OP_E_SET,
    OP_PP_MUL,
    OP_PP_ADD,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic       load;  // capture the input item
    dp_op_t     op;
    logic [3:0] idx;   // step index for table lookups and partial products
  } dp_cmd_t;

  typedef struct packed {
    logic pw_full;  // power is exactly 1.0
    logic pw_zero;  // power is exactly 0
  } dp_stat_t;

  typedef logic [15:0][31:0] chain_t;

  // Integer square root, used only while building constant tables.
  function automatic logic [63:0] isqrt_c(input logic [63:0] v);
    logic [63:0] xv;
    logic [63:0] rv;
    logic [63:0] bv;
    xv = v;
    rv = '0;
    bv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (xv >= rv + bv) begin
        xv = xv - (rv + bv);
        rv = (rv >> 1) + bv;
      end else begin
        rv = rv >> 1;
      end
      bv = bv >> 2;
    end
    return rv;
  endfunction

  // Factors 2^-(2^-(i+1)) in Q0.32 for the fractional power.
  function automatic chain_t exp_chain();
    logic [63:0] c;
    chain_t      tbl;
    c = 64'd1 << 31;
    for (int i = 0; i < 16; i++) begin
      c = isqrt_c(c << 32);
      tbl[i] = c[31:0];
    end
    return tbl;
  endfunction

  localparam chain_t EXP_CHAIN = exp_chain();

endpackage

### design/mltc_if.sv
// Handshake channels of the mixing-length turbulence column: input items,
// result items and configuration writes. Depends on mltc_pkg.

interface mltc_item_if import mltc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [16:0] volume_fraction;
  logic [31:0] cell_height;
  logic [31:0] strain_rate;
  logic        last_cell;

  modport source(output valid, volume_fraction, cell_height, strain_rate, last_cell,
                 input ready);
  modport sink(input valid, volume_fraction, cell_height, strain_rate, last_cell,
               output ready);
endinterface

interface mltc_result_if import mltc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] eddy_viscosity;
  logic [31:0] kinetic_energy;
  logic [31:0] dissipation;
  logic        saturated;
  logic        column_end;

  modport source(output valid, eddy_viscosity, kinetic_energy, dissipation, saturated,
                 column_end, input ready);
  modport sink(input valid, eddy_viscosity, kinetic_energy, dissipation, saturated,
               column_end, output ready);
endinterface

interface mltc_cfg_if import mltc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### design/mltc_dp.sv
// Datapath of the mixing-length column: configuration registers, running
// length, one shared 32x32 multiplier, a restoring divider and a square root
// unit. Depends on mltc_pkg; driven by commands from mltc_ctrl.

module mltc_dp import mltc_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  input  logic [16:0]            volume_fraction,
  input  logic [31:0]            cell_height,
  input  logic [31:0]            strain_rate,
  input  logic                   last_cell,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic [31:0]            eddy_viscosity,
  output logic [31:0]            kinetic_energy,
  output logic [31:0]            dissipation,
  output logic                   saturated,
  output logic                   column_end
);

  localparam int W      = VALUE_WIDTH;
  localparam int DIVN_W = 2 * VALUE_WIDTH + 32;
  localparam int DV_W   = VALUE_WIDTH + 8;
  localparam logic [W-1:0] VMAX = {W{1'b1}};

  // Configuration and running state.
  logic [16:0]  alpha_max;
  logic [15:0]  expo;
  logic [15:0]  kappa;
  logic [15:0]  cmu;
  logic [W-1:0] lm;

  // Item payload and working registers.
  logic [16:0]       alpha;
  logic [31:0]       height;
  logic [31:0]       strain;
  logic              last;
  logic              sat;
  logic [DIVN_W-1:0] nq;
  logic [DV_W-1:0]   rem;
  logic [DV_W-1:0]   dv;
  logic [16:0]       r;
  logic [3:0]        m;
  logic [31:0]       x;
  logic [15:0]       f;
  logic [8:0]        ip;
  logic [15:0]       fq;
  logic              pw_one;
  logic [31:0]       pwacc;
  logic [16:0]       p;
  logic [63:0]       mp;
  logic [1:0]        psh;
  logic [95:0]       opx;
  logic [63:0]       opy;
  logic [127:0]      acc;
  logic [W-1:0]      nut;
  logic [W-1:0]      k;
  logic [W-1:0]      eps;
  logic [63:0]       sx;
  logic [63:0]       res;
  logic [63:0]       bv;

  // Combinational helpers.
  logic [31:0]  mul_a;
  logic [31:0]  mul_b;
  logic [31:0]  opx_word;
  logic [31:0]  opy_word;
  logic [3:0]   m_c;
  logic [20:0]  nl;
  logic [31:0]  sq;
  logic [DV_W:0] rem2;
  logic         div_ge;
  logic [63:0]  lm_sum;
  logic [W-1:0] dmin;
  logic [W+2:0] nut5;
  logic [32:0]  pw_shift;
  logic [32:0]  clip_nut;
  logic [32:0]  clip_k;
  logic [32:0]  clip_eps;

  // Clip a result to 32 bits; the top bit flags the clip.
  function automatic logic [32:0] clip32(input logic [W-1:0] v);
    logic [63:0] v64;
    v64 = 64'(v);
    if (v64[63:32] != 32'd0) return {1'b1, 32'hFFFF_FFFF};
    return {1'b0, v64[31:0]};
  endfunction

  assign stat.pw_full = r[16] || (expo == 16'd0);
  assign stat.pw_zero = (r == 17'd0);

  // Leading one of the ratio.
  always_comb begin
    m_c = '0;
    for (int i = 0; i < 16; i++) begin
      if (r[i]) m_c = 4'(i);
    end
  end

  assign nl       = {(5'd16 - {1'b0, m}), 16'd0} - {5'd0, f};
  assign sq       = mp[61:30];
  assign rem2     = {rem, nq[DIVN_W-1]};
  assign div_ge   = (rem2 >= {1'b0, dv});
  assign lm_sum   = 64'(lm) + acc[95:32];
  assign dmin     = (lm > W'(LM_SMALL)) ? lm : W'(LM_SMALL);
  assign nut5     = (W+3)'(nut) + ((W+3)'(nut) << 2);
  assign pw_shift = {pw_one, pwacc} >> (6'd16 + {1'b0, ip[4:0]});
  assign clip_nut = clip32(nut);
  assign clip_k   = clip32(k);
  assign clip_eps = clip32(eps);

  // Operand words for the partial products.
  always_comb begin
    unique case (cmd.idx[2:1])
      2'd0:    opx_word = opx[31:0];
      2'd1:    opx_word = opx[63:32];
      default: opx_word = opx[95:64];
    endcase
    opy_word = cmd.idx[0] ? opy[63:32] : opy[31:0];
  end

  // Shared multiplier input selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_SQ_MUL: begin
        mul_a = x;
        mul_b = x;
      end
      OP_LOG_MUL: begin
        mul_a = 32'(nl);
        mul_b = 32'(expo);
      end
      OP_EXP_MUL: begin
        mul_a = pwacc;
        mul_b = EXP_CHAIN[cmd.idx];
      end
      OP_PP_MUL: begin
        mul_a = opx_word;
        mul_b = opy_word;
      end
      default: ;
    endcase
  end

  // Configuration registers and the running mixing length.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_max <= ALPHA_MAX_RST;
      expo      <= EXPONENT_RST;
      kappa     <= KAPPA_RST;
      cmu       <= CMU_RST;
      lm        <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ALPHA_MAX: alpha_max <= cfg_data;
          REG_EXPONENT:  expo      <= cfg_data[15:0];
          REG_KAPPA:     kappa     <= cfg_data[15:0];
          REG_CMU:       cmu       <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_LM_UPD) begin
        lm <= (lm_sum[63:W] != '0) ? VMAX : lm_sum[W-1:0];
      end else if (cmd.op == OP_OUT && last) begin
        lm <= '0;
      end
    end
  end

  // Working registers, stepped by the command of each cycle.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      alpha  <= volume_fraction;
      height <= cell_height;
      strain <= strain_rate;
      last   <= last_cell;
      sat    <= 1'b0;
    end
    unique case (cmd.op)
      OP_DIV_INIT_R: begin
        nq  <= DIVN_W'({alpha, 16'd0});
        dv  <= DV_W'(alpha_max);
        rem <= '0;
      end
      OP_DIV_STEP: begin
        rem <= div_ge ? DV_W'(rem2 - {1'b0, dv}) : rem2[DV_W-1:0];
        nq  <= {nq[DIVN_W-2:0], div_ge};
      end
      OP_R_SET: r <= (nq[DIVN_W-1:16] != '0) ? ONE_Q16 : {1'b0, nq[15:0]};
      OP_P_ONE:  p <= ONE_Q16;
      OP_P_ZERO: p <= '0;
      OP_PW_NORM: begin
        m <= m_c;
        x <= 32'(r[15:0]) << (5'd30 - {1'b0, m_c});
        f <= '0;
      end
      OP_SQ_MUL, OP_LOG_MUL, OP_EXP_MUL: mp <= mul_a * mul_b;
      OP_SQ_ACC: begin
        if (sq[31]) begin
          x <= {1'b0, sq[31:1]};
          f <= {f[14:0], 1'b1};
        end else begin
          x <= sq;
          f <= {f[14:0], 1'b0};
        end
      end
      OP_LOG_ACC: begin
        ip     <= mp[36:28];
        fq     <= mp[27:12];
        pw_one <= 1'b1;
        pwacc  <= '0;
      end
      OP_EXP_ACC: begin
        if (fq[4'd15 - cmd.idx]) begin
          pwacc  <= pw_one ? EXP_CHAIN[cmd.idx] : mp[63:32];
          pw_one <= 1'b0;
        end
      end
      OP_P_SET: p <= (ip > 9'd16) ? 17'd0 : pw_shift[16:0];
      OP_LD_INC1: begin
        opx <= 96'(kappa);
        opy <= 64'(ONE_Q16 - p);
        acc <= '0;
      end
      OP_LD_INC2: begin
        opx <= 96'(acc[32:0]);
        opy <= 64'(height);
        acc <= '0;
      end
      OP_LM_UPD: begin
        if (lm_sum[63:W] != '0) sat <= 1'b1;
      end
      OP_LD_SQ: begin
        opx <= 96'(lm);
        opy <= 64'(lm);
        acc <= '0;
      end
      OP_LD_NUT: begin
        opx <= acc[95:0];
        opy <= 64'(strain);
        acc <= '0;
      end
      OP_NUT_SET: begin
        if (acc[127:48+W] != '0) begin
          nut <= VMAX;
          sat <= 1'b1;
        end else begin
          nut <= acc[48+W-1:48];
        end
      end
      OP_DIV_INIT_Q: begin
        nq  <= DIVN_W'({nut5, 22'd0});
        dv  <= DV_W'(dmin);
        rem <= '0;
      end
      OP_LD_K: begin
        opx <= 96'(nq[63:0]);
        opy <= nq[63:0];
        acc <= '0;
      end
      OP_K_SET: begin
        if (acc[127:16+W] != '0) begin
          k   <= VMAX;
          sat <= 1'b1;
        end else begin
          k <= acc[16+W-1:16];
        end
      end
      OP_SQRT_INIT: begin
        sx  <= 64'({k, 16'd0});
        res <= '0;
        bv  <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT_STEP: begin
        if (sx >= res + bv) begin
          sx  <= sx - (res + bv);
          res <= (res >> 1) + bv;
        end else begin
          res <= res >> 1;
        end
        bv <= bv >> 2;
      end
      OP_LD_SC: begin
        opx <= 96'(res[31:0]);
        opy <= 64'(cmu);
        acc <= '0;
      end
      OP_LD_EN: begin
        opx <= 96'(k);
        opy <= acc[63:0];
        acc <= '0;
      end
      OP_DIV_INIT_E: begin
        nq  <= acc[DIVN_W-1:0];
        dv  <= {dmin, 8'd0};
        rem <= '0;
      end
      OP_E_SET: begin
        if (nq[DIVN_W-1:W] != '0) begin
          eps <= VMAX;
          sat <= 1'b1;
        end else begin
          eps <= nq[W-1:0];
        end
      end
      OP_PP_MUL: begin
        mp  <= mul_a * mul_b;
        psh <= cmd.idx[2:1] + {1'b0, cmd.idx[0]};
      end
      OP_PP_ADD: acc <= acc + (128'(mp) << {psh, 5'd0});
      OP_OUT: begin
        eddy_viscosity <= clip_nut[31:0];
        kinetic_energy <= clip_k[31:0];
        dissipation    <= clip_eps[31:0];
        saturated      <= sat | clip_nut[32] | clip_k[32] | clip_eps[32];
        column_end     <= last;
      end
      default: ;
    endcase
  end

endmodule

### design/mltc_ctrl.sv
// Sequencer of the mixing-length column: walks one cell through ratio,
// power, length update, products, divisions and square root. Depends on
// mltc_pkg; commands mltc_dp.

module mltc_ctrl import mltc_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  localparam int DIVN_W = 2 * VALUE_WIDTH + 32;
  localparam int CNT_W  = $clog2(DIVN_W);

  typedef enum logic [4:0] {
    S_IDLE, S_RINIT, S_RDIV, S_RSET, S_PW, S_SQM, S_SQA, S_LOGM, S_LOGA,
    S_EXPM, S_EXPA, S_PSET, S_LD, S_PPM, S_PPA, S_LMUPD, S_NUTSET,
    S_QINIT, S_QDIV, S_KSET, S_SQRTI, S_SQRT, S_EINIT, S_EDIV, S_ESET,
    S_FINISH
  } state_t;

  // Which long product the partial-product loop is working on.
  typedef enum logic [2:0] {
    MP_INC1, MP_INC2, MP_SQ, MP_NUT, MP_K, MP_SC, MP_EN
  } mphase_t;

  state_t           state;
  mphase_t          mphase;
  logic [CNT_W-1:0] cnt;
  logic             out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Command decode from the current state.
  always_comb begin
    cmd.load = 1'b0;
    cmd.op   = OP_NONE;
    cmd.idx  = cnt[3:0];
    unique case (state)
      S_IDLE:   cmd.load = in_valid;
      S_RINIT:  cmd.op = OP_DIV_INIT_R;
      S_RDIV, S_QDIV, S_EDIV: cmd.op = OP_DIV_STEP;
      S_RSET:   cmd.op = OP_R_SET;
      S_PW: begin
        priority if (stat.pw_full) cmd.op = OP_P_ONE;
        else if (stat.pw_zero)     cmd.op = OP_P_ZERO;
        else                       cmd.op = OP_PW_NORM;
      end
      S_SQM:    cmd.op = OP_SQ_MUL;
      S_SQA:    cmd.op = OP_SQ_ACC;
      S_LOGM:   cmd.op = OP_LOG_MUL;
      S_LOGA:   cmd.op = OP_LOG_ACC;
      S_EXPM:   cmd.op = OP_EXP_MUL;
      S_EXPA:   cmd.op = OP_EXP_ACC;
      S_PSET:   cmd.op = OP_P_SET;
      S_LD: begin
        unique case (mphase)
          MP_INC1: cmd.op = OP_LD_INC1;
          MP_INC2: cmd.op = OP_LD_INC2;
          MP_SQ:   cmd.op = OP_LD_SQ;
          MP_NUT:  cmd.op = OP_LD_NUT;
          MP_K:    cmd.op = OP_LD_K;
          MP_SC:   cmd.op = OP_LD_SC;
          MP_EN:   cmd.op = OP_LD_EN;
          default: cmd.op = OP_NONE;
        endcase
      end
      S_PPM:    cmd.op = OP_PP_MUL;
      S_PPA:    cmd.op = OP_PP_ADD;
      S_LMUPD:  cmd.op = OP_LM_UPD;
      S_NUTSET: cmd.op = OP_NUT_SET;
      S_QINIT:  cmd.op = OP_DIV_INIT_Q;
      S_KSET:   cmd.op = OP_K_SET;
      S_SQRTI:  cmd.op = OP_SQRT_INIT;
      S_SQRT:   cmd.op = OP_SQRT_STEP;
      S_EINIT:  cmd.op = OP_DIV_INIT_E;
      S_ESET:   cmd.op = OP_E_SET;
      S_FINISH: cmd.op = out_free ? OP_OUT : OP_NONE;
      default:  cmd.op = OP_NONE;
    endcase
  end

  // State, loop counter, product phase and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mphase    <= MP_INC1;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // Result valid is set when a result is loaded and cleared by its transfer.
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_RINIT;
        end
        S_RINIT: begin
          cnt   <= CNT_W'(DIVN_W - 1);
          state <= S_RDIV;
        end
        S_RDIV: begin
          if (cnt == '0) state <= S_RSET;
          else cnt <= cnt - 1'b1;
        end
        S_RSET: state <= S_PW;
        S_PW: begin
          if (stat.pw_full || stat.pw_zero) begin
            mphase <= MP_INC1;
            state  <= S_LD;
          end else begin
            cnt   <= CNT_W'(15);
            state <= S_SQM;
          end
        end
        S_SQM: state <= S_SQA;
        S_SQA: begin
          if (cnt == '0) state <= S_LOGM;
          else begin
            cnt   <= cnt - 1'b1;
            state <= S_SQM;
          end
        end
        S_LOGM: state <= S_LOGA;
        S_LOGA: begin
          cnt   <= '0;
          state <= S_EXPM;
        end
        S_EXPM: state <= S_EXPA;
        S_EXPA: begin
          if (cnt == CNT_W'(15)) state <= S_PSET;
          else begin
            cnt   <= cnt + 1'b1;
            state <= S_EXPM;
          end
        end
        S_PSET: begin
          mphase <= MP_INC1;
          state  <= S_LD;
        end
        S_LD: begin
          cnt   <= '0;
          state <= S_PPM;
        end
        S_PPM: state <= S_PPA;
        S_PPA: begin
          if (cnt == CNT_W'(5)) begin
            unique case (mphase)
              MP_INC1: begin
                mphase <= MP_INC2;
                state  <= S_LD;
              end
              MP_INC2: state <= S_LMUPD;
              MP_SQ: begin
                mphase <= MP_NUT;
                state  <= S_LD;
              end
              MP_NUT: state <= S_NUTSET;
              MP_K:   state <= S_KSET;
              MP_SC: begin
                mphase <= MP_EN;
                state  <= S_LD;
              end
              MP_EN:   state <= S_EINIT;
              default: state <= S_IDLE;
            endcase
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_PPM;
          end
        end
        S_LMUPD: begin
          mphase <= MP_SQ;
          state  <= S_LD;
        end
        S_NUTSET: state <= S_QINIT;
        S_QINIT: begin
          cnt   <= CNT_W'(DIVN_W - 1);
          state <= S_QDIV;
        end
        S_QDIV: begin
          if (cnt == '0) begin
            mphase <= MP_K;
            state  <= S_LD;
          end else cnt <= cnt - 1'b1;
        end
        S_KSET: state <= S_SQRTI;
        S_SQRTI: begin
          cnt   <= CNT_W'(31);
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (cnt == '0) begin
            mphase <= MP_SC;
            state  <= S_LD;
          end else cnt <= cnt - 1'b1;
        end
        S_EINIT: begin
          cnt   <= CNT_W'(DIVN_W - 1);
          state <= S_EDIV;
        end
        S_EDIV: begin
          if (cnt == '0) state <= S_ESET;
          else cnt <= cnt - 1'b1;
        end
        S_ESET: state <= S_FINISH;
        S_FINISH: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/mixing_length_turbulence_column.sv
// Top level of the mixing-length turbulence column: joins the sequencer and
// the datapath to the channels. Depends on mltc_pkg, mltc_if, mltc_ctrl, mltc_dp.
//
//   channel   direction  carries
//   items     in         volume_fraction, cell_height, strain_rate, last_cell
//   results   out        eddy_viscosity, kinetic_energy, dissipation, saturated,
//                        column_end
//   cfg       in         index, data (alpha_max, exponent, kappa, cmu_three_quarters)
//
// The three bit-serial divisions dominate the time per cell, then the power
// loops (skipped when the power is exactly one or zero) and seven long
// products on the one shared 32x32 multiplier.
// Reset (synchronous, high) restores the register defaults and clears the length.
// A finished result waits in the output register while the next item is taken;
// if it is still not taken at the end of that item, the sequencer holds.
// Configuration writes are taken in every cycle.

module mixing_length_turbulence_column import mltc_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  mltc_item_if.sink     items,
  mltc_result_if.source results,
  mltc_cfg_if.sink      cfg
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg.ready = 1'b1;

  // Sequencer.
  mltc_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .out_valid(results.valid),
    .out_ready(results.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Arithmetic and state.
  mltc_dp #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .volume_fraction(items.volume_fraction),
    .cell_height    (items.cell_height),
    .strain_rate    (items.strain_rate),
    .last_cell      (items.last_cell),
    .cfg_valid      (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .eddy_viscosity (results.eddy_viscosity),
    .kinetic_energy (results.kinetic_energy),
    .dissipation    (results.dissipation),
    .saturated      (results.saturated),
    .column_end     (results.column_end)
  );

endmodule
